// File: design/spi_msc_pkg.sv
// spi_msc_pkg: shared types, codes and constants of the spi controller
// used by every module in the design folder; depends on nothing

package spi_msc_pkg;

    localparam int DATA_BITS = 8;
    localparam int CNT_W     = 4;
    localparam int PRE_W     = 7;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 3;
    localparam logic [7:0] BYTE_MASK = 8'hFF;
    localparam logic [CNT_W-1:0] LAST_EDGE = CNT_W'(2 * DATA_BITS - 1);

    // bus access codes
    localparam logic [1:0] FUNC_NONE   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_STATUS = 2'd3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MASTER   = 3'd1;
    localparam logic [IDX_W-1:0] REG_LSB      = 3'd2;
    localparam logic [IDX_W-1:0] REG_CPOL     = 3'd3;
    localparam logic [IDX_W-1:0] REG_CPHA     = 3'd4;
    localparam logic [IDX_W-1:0] REG_RATE     = 3'd5;
    localparam logic [IDX_W-1:0] REG_INT_EN   = 3'd6;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] write_data;
        logic       miso_in;
        logic       mosi_in;
        logic       sck_in;
        logic       select_n_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       done_flag;
        logic       irq;
        logic       sck_out;
        logic       mosi_out;
        logic       miso_out;
        logic       busy_res;
    } out_item_t;

    typedef struct packed {
        logic       enable;
        logic       master_mode;
        logic       lsb_order;
        logic       sck_idle;
        logic       sck_phase;
        logic [2:0] rate_select;
        logic       int_enable;
    } cfg_t;

    // side effects of a configuration write on the transfer state
    typedef struct packed {
        logic abort;
        logic pol_set;
        logic pol_val;
    } cfg_evt_t;

    // prescaler compare value: half serial period minus one
    function automatic logic [PRE_W-1:0] half_limit(input logic [2:0] rate);
        logic [PRE_W-1:0] lim;
        case (rate)
            3'd0:    lim = 7'd1;
            3'd1:    lim = 7'd7;
            3'd2:    lim = 7'd31;
            3'd3:    lim = 7'd63;
            3'd4:    lim = 7'd0;
            3'd5:    lim = 7'd3;
            3'd6:    lim = 7'd15;
            default: lim = 7'd31;
        endcase
        return lim;
    endfunction

endpackage

// File: design/spi_msc_cfg.sv
// spi_msc_cfg: configuration registers and the events a write raises
// depends on spi_msc_pkg

module spi_msc_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [spi_msc_pkg::IDX_W-1:0] cfg_index,
    input  logic [spi_msc_pkg::CFG_W-1:0] cfg_data,
    output spi_msc_pkg::cfg_t            cfg,
    output spi_msc_pkg::cfg_evt_t        evt
);

    spi_msc_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                spi_msc_pkg::REG_ENABLE: cfg_next.enable      = cfg_data[0];
                spi_msc_pkg::REG_MASTER: cfg_next.master_mode = cfg_data[0];
                spi_msc_pkg::REG_LSB:    cfg_next.lsb_order   = cfg_data[0];
                spi_msc_pkg::REG_CPOL:   cfg_next.sck_idle    = cfg_data[0];
                spi_msc_pkg::REG_CPHA:   cfg_next.sck_phase   = cfg_data[0];
                spi_msc_pkg::REG_RATE:   cfg_next.rate_select = cfg_data;
                spi_msc_pkg::REG_INT_EN: cfg_next.int_enable  = cfg_data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        evt.abort   = cfg_wr_en &&
                      (((cfg_index == spi_msc_pkg::REG_ENABLE) &&
                        (cfg_data[0] != cfg_reg.enable)) ||
                       ((cfg_index == spi_msc_pkg::REG_MASTER) &&
                        (cfg_data[0] != cfg_reg.master_mode)));
        evt.pol_set = cfg_wr_en && (cfg_index == spi_msc_pkg::REG_CPOL);
        evt.pol_val = cfg_data[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/spi_msc_in_stage.sv
// spi_msc_in_stage: input register that holds one transaction for the core
// depends on spi_msc_pkg

module spi_msc_in_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  spi_msc_pkg::in_item_t s_data,
    output logic                  item_valid,
    input  logic                  item_ready,
    output spi_msc_pkg::in_item_t item
);

    logic                  valid_reg, valid_next;
    spi_msc_pkg::in_item_t data_reg, data_next;
    logic                  pop;

    assign pop     = valid_reg && item_ready;
    assign s_ready = !valid_reg || item_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (pop) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            data_next  = s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// File: design/spi_msc_core.sv
// spi_msc_core: transfer state, state update per accepted transaction, result register
// depends on spi_msc_pkg

module spi_msc_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  spi_msc_pkg::cfg_t      cfg,
    input  spi_msc_pkg::cfg_evt_t  evt,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  spi_msc_pkg::in_item_t  item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output spi_msc_pkg::out_item_t m_data
);

    typedef struct packed {
        logic [7:0]                    shift;
        logic [7:0]                    rx;
        logic [spi_msc_pkg::CNT_W-1:0] cnt;
        logic [spi_msc_pkg::PRE_W-1:0] pre;
        logic                          lvl;
        logic                          prev_sck;
        logic                          flag;
        logic                          active;
        logic                          held;
    } state_t;

    state_t                 st_reg, st_next;
    logic                   out_valid_reg, out_valid_next;
    spi_msc_pkg::out_item_t out_reg, out_next;
    logic                   fire;

    function automatic logic first_bit(input logic [7:0] sh, input logic lsb);
        return lsb ? sh[0] : sh[7];
    endfunction

    // one serial clock edge, leading means leaving the idle level
    function automatic state_t serial_edge(input state_t s, input logic leading,
                                           input logic in_bit, input spi_msc_pkg::cfg_t c);
        state_t r;
        logic   sample;
        r      = s;
        sample = c.sck_phase ? !leading : leading;
        if (sample) begin
            if (c.lsb_order) begin
                r.shift = {in_bit, s.shift[7:1]};
            end else begin
                r.shift = {s.shift[6:0], in_bit};
            end
        end else begin
            r.held = first_bit(s.shift, c.lsb_order);
        end
        if (s.cnt == spi_msc_pkg::LAST_EDGE) begin
            r.rx     = r.shift & spi_msc_pkg::BYTE_MASK;
            r.flag   = 1'b1;
            r.active = 1'b0;
            r.cnt    = '0;
            r.pre    = '0;
            r.lvl    = c.sck_idle;
        end else begin
            r.cnt = s.cnt + 1'b1;
        end
        return r;
    endfunction

    assign item_ready = !out_valid_reg || m_ready;
    assign fire       = item_valid && item_ready;

    always_comb begin
        state_t s;
        logic   started;
        logic   out_bit;
        s        = st_reg;
        started  = 1'b0;
        out_bit  = 1'b0;
        out_next = out_reg;
        if (fire) begin
            if (item.func == spi_msc_pkg::FUNC_WRITE || item.func == spi_msc_pkg::FUNC_READ) begin
                s.flag = 1'b0;
            end
            if (item.func == spi_msc_pkg::FUNC_WRITE && cfg.enable && !s.active) begin
                s.shift = item.write_data;
                if (cfg.master_mode) begin
                    s.active = 1'b1;
                    s.cnt    = '0;
                    s.pre    = '0;
                    s.lvl    = cfg.sck_idle;
                    s.held   = first_bit(item.write_data, cfg.lsb_order);
                    started  = 1'b1;
                end
            end
            if (cfg.enable && cfg.master_mode) begin
                if (s.active && !started) begin
                    if (s.pre >= spi_msc_pkg::half_limit(cfg.rate_select)) begin
                        s.pre = '0;
                        s.lvl = !s.lvl;
                        s = serial_edge(s, s.lvl != cfg.sck_idle, item.miso_in, cfg);
                    end else begin
                        s.pre = s.pre + 1'b1;
                    end
                end
            end else if (cfg.enable) begin
                if (item.select_n_in) begin
                    s.active = 1'b0;
                    s.cnt    = '0;
                end else if (item.sck_in != s.prev_sck) begin
                    if (!s.active) begin
                        s.active = 1'b1;
                        s.cnt    = '0;
                        s.held   = first_bit(s.shift, cfg.lsb_order);
                    end
                    s = serial_edge(s, item.sck_in != cfg.sck_idle, item.mosi_in, cfg);
                end
            end
            s.prev_sck = item.sck_in;

            out_bit = s.active ? s.held : first_bit(s.shift, cfg.lsb_order);
            case (item.func)
                spi_msc_pkg::FUNC_READ:   out_next.read_data = s.rx;
                spi_msc_pkg::FUNC_STATUS: out_next.read_data = {s.flag, 6'd0, cfg.rate_select[2]};
                default:                  out_next.read_data = 8'd0;
            endcase
            out_next.done_flag = s.flag;
            out_next.irq       = s.flag && cfg.int_enable;
            out_next.sck_out   = (s.active && cfg.enable && cfg.master_mode) ?
                                 s.lvl : cfg.sck_idle;
            out_next.mosi_out  = (cfg.enable && cfg.master_mode) ? out_bit : 1'b0;
            out_next.miso_out  = (cfg.enable && !cfg.master_mode && !item.select_n_in) ?
                                 out_bit : 1'b0;
            out_next.busy_res  = s.active;
        end

        // mode change aborts, polarity write moves the idle level
        if (evt.abort) begin
            s.active = 1'b0;
            s.cnt    = '0;
            s.pre    = '0;
            s.lvl    = cfg.sck_idle;
        end
        if (evt.pol_set && !s.active) begin
            s.lvl = evt.pol_val;
        end
        st_next = s;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (fire) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    // a transfer only runs while the block is enabled
    a_active_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.active |-> cfg.enable)
        else $error("transfer active while disabled");

    // edge count is cleared whenever no transfer runs
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.cnt != '0) |-> st_reg.active)
        else $error("edge count nonzero with no transfer");

    // prescaler only counts during a master transfer
    a_pre_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.pre != '0) |-> (st_reg.active && cfg.master_mode))
        else $error("prescaler running with no master transfer");

    // interrupt never without the done flag in a pending result
    a_irq_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (!out_reg.irq || out_reg.done_flag))
        else $error("irq without done flag");

    // a stalled transaction in the core does not advance state
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && !item_ready && !evt.abort && !evt.pol_set) |=> $stable(st_reg))
        else $error("state changed while stalled");
`endif

endmodule

// File: design/spi_master_slave_controller.sv
// spi_master_slave_controller: 8-bit spi master/slave port, one transaction per system cycle
// pipeline: two register stages (input register, then the state update into the result
// register); m_valid rises once the core takes the item. throughput: one transaction
// per cycle, limited only by m_ready back-pressure. synchronous active-low reset clears the
// configuration, the shift, receive, count and prescaler state, the done flag and both valid bits
// depends on spi_msc_pkg, spi_msc_cfg, spi_msc_in_stage, spi_msc_core

module spi_master_slave_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [spi_msc_pkg::IDX_W-1:0] cfg_index,
    input  logic [spi_msc_pkg::CFG_W-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  spi_msc_pkg::in_item_t         s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output spi_msc_pkg::out_item_t        m_data
);

    spi_msc_pkg::cfg_t     cfg;
    spi_msc_pkg::cfg_evt_t evt;
    spi_msc_pkg::in_item_t item;
    logic                  item_valid;
    logic                  item_ready;

    spi_msc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .evt       (evt)
    );

    spi_msc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    spi_msc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .evt        (evt),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// File: verif/tb.sv
// tb: self-checking testbench for spi_master_slave_controller
// drives bus accesses and pin levels, predicts every result cycle and compares it
// depends on spi_msc_pkg and the design under design/
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [spi_msc_pkg::IDX_W-1:0] cfg_index = '0;
    logic [spi_msc_pkg::CFG_W-1:0] cfg_data  = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    spi_msc_pkg::in_item_t         s_data    = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    spi_msc_pkg::out_item_t        m_data;

    spi_master_slave_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #2 aclk = ~aclk;

    // shadow copy of the controller state
    spi_msc_pkg::cfg_t shadow_cfg;
    logic [7:0] sh_shift;
    logic [7:0] sh_rx;
    logic [3:0] sh_edges;
    logic [6:0] sh_presc;
    logic       sh_level;
    logic       sh_prev_sck;
    logic       sh_done;
    logic       sh_busy;
    logic       sh_held;

    spi_msc_pkg::out_item_t pending_outputs[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        sent_count    = 0;
    int        result_count  = 0;
    int        error_count   = 0;
    int        cycle_count   = 0;

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic spi_msc_pkg::in_item_t mk(input logic [1:0] func,
                                                 input logic [7:0] wdata,
                                                 input logic miso, input logic mosi,
                                                 input logic sck, input logic sel_n);
        spi_msc_pkg::in_item_t it;
        it.func        = func;
        it.write_data  = wdata;
        it.miso_in     = miso;
        it.mosi_in     = mosi;
        it.sck_in      = sck;
        it.select_n_in = sel_n;
        return it;
    endfunction

    function automatic spi_msc_pkg::in_item_t rand_item();
        logic [31:0] raw;
        raw = $urandom;
        return spi_msc_pkg::in_item_t'(raw[$bits(spi_msc_pkg::in_item_t)-1:0]);
    endfunction

    function automatic logic [6:0] half_cycles(input logic [2:0] rate);
        case (rate)
            3'd0: return 7'd2;
            3'd1: return 7'd8;
            3'd2: return 7'd32;
            3'd3: return 7'd64;
            3'd4: return 7'd1;
            3'd5: return 7'd4;
            3'd6: return 7'd16;
            default: return 7'd32;
        endcase
    endfunction

    function automatic logic lead_bit();
        return shadow_cfg.lsb_order ? sh_shift[0] : sh_shift[7];
    endfunction

    function automatic void drop_transfer();
        sh_busy  = 1'b0;
        sh_edges = '0;
        sh_presc = '0;
        sh_level = shadow_cfg.sck_idle;
    endfunction

    function automatic void reset_shadow();
        shadow_cfg  = '0;
        sh_shift    = '0;
        sh_rx       = '0;
        sh_edges    = '0;
        sh_presc    = '0;
        sh_level    = 1'b0;
        sh_prev_sck = 1'b0;
        sh_done     = 1'b0;
        sh_busy     = 1'b0;
        sh_held     = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [spi_msc_pkg::IDX_W-1:0] idx,
                                      input logic [spi_msc_pkg::CFG_W-1:0] val);
        case (idx)
            spi_msc_pkg::REG_ENABLE: begin
                if (val[0] != shadow_cfg.enable) drop_transfer();
                shadow_cfg.enable = val[0];
            end
            spi_msc_pkg::REG_MASTER: begin
                if (val[0] != shadow_cfg.master_mode) drop_transfer();
                shadow_cfg.master_mode = val[0];
            end
            spi_msc_pkg::REG_LSB:    shadow_cfg.lsb_order = val[0];
            spi_msc_pkg::REG_CPOL: begin
                shadow_cfg.sck_idle = val[0];
                if (!sh_busy) sh_level = val[0];
            end
            spi_msc_pkg::REG_CPHA:   shadow_cfg.sck_phase = val[0];
            spi_msc_pkg::REG_RATE:   shadow_cfg.rate_select = val;
            spi_msc_pkg::REG_INT_EN: shadow_cfg.int_enable = val[0];
            default: ;
        endcase
    endfunction

    // one serial clock transition; leading means leaving the idle level
    function automatic void serial_transition(input logic leading, input logic din);
        if (shadow_cfg.sck_phase ? !leading : leading) begin
            if (shadow_cfg.lsb_order) sh_shift = {din, sh_shift[7:1]};
            else sh_shift = {sh_shift[6:0], din};
        end else begin
            sh_held = lead_bit();
        end
        if (sh_edges >= spi_msc_pkg::LAST_EDGE) begin
            sh_rx   = sh_shift;
            sh_done = 1'b1;
            drop_transfer();
        end else begin
            sh_edges = sh_edges + 4'd1;
        end
    endfunction

    function automatic spi_msc_pkg::out_item_t predict_cycle(input spi_msc_pkg::in_item_t it);
        spi_msc_pkg::out_item_t r;
        logic       started;
        logic [6:0] lim;
        logic       bit_now;
        r       = '0;
        started = 1'b0;
        if (it.func == spi_msc_pkg::FUNC_WRITE || it.func == spi_msc_pkg::FUNC_READ)
            sh_done = 1'b0;
        if (it.func == spi_msc_pkg::FUNC_WRITE && shadow_cfg.enable && !sh_busy) begin
            sh_shift = it.write_data;
            if (shadow_cfg.master_mode) begin
                sh_busy  = 1'b1;
                sh_edges = '0;
                sh_presc = '0;
                sh_level = shadow_cfg.sck_idle;
                sh_held  = lead_bit();
                started  = 1'b1;
            end
        end
        if (shadow_cfg.enable && shadow_cfg.master_mode) begin
            if (sh_busy && !started) begin
                lim = half_cycles(shadow_cfg.rate_select) - 7'd1;
                if (sh_presc >= lim) begin
                    sh_presc = '0;
                    sh_level = ~sh_level;
                    serial_transition(sh_level != shadow_cfg.sck_idle, it.miso_in);
                end else begin
                    sh_presc = sh_presc + 7'd1;
                end
            end
        end else if (shadow_cfg.enable) begin
            if (it.select_n_in) begin
                sh_busy  = 1'b0;
                sh_edges = '0;
            end else if (it.sck_in != sh_prev_sck) begin
                if (!sh_busy) begin
                    sh_busy  = 1'b1;
                    sh_edges = '0;
                    sh_held  = lead_bit();
                end
                serial_transition(it.sck_in != shadow_cfg.sck_idle, it.mosi_in);
            end
        end
        sh_prev_sck = it.sck_in;

        bit_now = sh_busy ? sh_held : lead_bit();
        case (it.func)
            spi_msc_pkg::FUNC_READ:   r.read_data = sh_rx;
            spi_msc_pkg::FUNC_STATUS: r.read_data = {sh_done, 6'd0, shadow_cfg.rate_select[2]};
            default: ;
        endcase
        r.done_flag = sh_done;
        r.irq       = sh_done & shadow_cfg.int_enable;
        r.sck_out   = (sh_busy && shadow_cfg.enable && shadow_cfg.master_mode) ?
                      sh_level : shadow_cfg.sck_idle;
        r.mosi_out  = (shadow_cfg.enable && shadow_cfg.master_mode) ? bit_now : 1'b0;
        r.miso_out  = (shadow_cfg.enable && !shadow_cfg.master_mode && !it.select_n_in) ?
                      bit_now : 1'b0;
        r.busy_res  = sh_busy;
        return r;
    endfunction

    // send one transaction, idling before it at the current rate
    task automatic send(input spi_msc_pkg::in_item_t it);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_outputs.push_back(predict_cycle(it));
        sent_count++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [spi_msc_pkg::IDX_W-1:0] idx,
                             input logic [spi_msc_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        apply_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_config(input spi_msc_pkg::cfg_t c);
        write_reg(spi_msc_pkg::REG_ENABLE, spi_msc_pkg::CFG_W'(c.enable));
        write_reg(spi_msc_pkg::REG_MASTER, spi_msc_pkg::CFG_W'(c.master_mode));
        write_reg(spi_msc_pkg::REG_LSB, spi_msc_pkg::CFG_W'(c.lsb_order));
        write_reg(spi_msc_pkg::REG_CPOL, spi_msc_pkg::CFG_W'(c.sck_idle));
        write_reg(spi_msc_pkg::REG_CPHA, spi_msc_pkg::CFG_W'(c.sck_phase));
        write_reg(spi_msc_pkg::REG_RATE, c.rate_select);
        write_reg(spi_msc_pkg::REG_INT_EN, spi_msc_pkg::CFG_W'(c.int_enable));
    endtask

    // load a byte and clock it out, with the odd access mixed in
    task automatic run_master_transfer();
        spi_msc_pkg::in_item_t it;
        int       guard;
        send(mk(spi_msc_pkg::FUNC_WRITE, 8'($urandom), rbit(), rbit(), rbit(), rbit()));
        guard = 0;
        while (sh_busy && guard < 2200) begin
            it = rand_item();
            case ($urandom_range(0, 39))
                0: it.func = spi_msc_pkg::FUNC_STATUS;
                1: it.func = spi_msc_pkg::FUNC_WRITE;
                2: it.func = spi_msc_pkg::FUNC_READ;
                default: it.func = spi_msc_pkg::FUNC_NONE;
            endcase
            send(it);
            guard++;
        end
        send(mk(spi_msc_pkg::FUNC_STATUS, 8'($urandom), rbit(), rbit(), rbit(), rbit()));
        send(mk(spi_msc_pkg::FUNC_READ, 8'($urandom), rbit(), rbit(), rbit(), rbit()));
    endtask

    // preload, select, then sixteen external clock transitions of random width
    task automatic run_slave_transfer();
        spi_msc_pkg::in_item_t it;
        logic     lvl;
        int       e;
        int       h;
        lvl = shadow_cfg.sck_idle ^ ($urandom_range(0, 9) == 0);
        send(mk(spi_msc_pkg::FUNC_WRITE, 8'($urandom), rbit(), rbit(), lvl,
                $urandom_range(0, 4) != 0));
        send(mk(spi_msc_pkg::FUNC_NONE, 8'($urandom), rbit(), rbit(), lvl, 1'b0));
        for (e = 0; e < 16; e++) begin
            lvl = ~lvl;
            for (h = $urandom_range(1, 3); h > 0; h--) begin
                it = mk(spi_msc_pkg::FUNC_NONE, 8'($urandom), rbit(), rbit(), lvl,
                        $urandom_range(0, 59) == 0);
                if ($urandom_range(0, 19) == 0) it.func = 2'($urandom_range(0, 3));
                send(it);
            end
        end
        send(mk(spi_msc_pkg::FUNC_STATUS, 8'($urandom), rbit(), rbit(), lvl, 1'b0));
        send(mk(spi_msc_pkg::FUNC_READ, 8'($urandom), rbit(), rbit(), lvl, 1'b1));
    endtask

    task automatic run_block(input int n);
        spi_msc_pkg::cfg_t c;
        int   start;
        int   k;
        wait_drained();
        c.enable      = $urandom_range(0, 9) != 0;
        c.master_mode = rbit();
        c.lsb_order   = rbit();
        c.sck_idle    = rbit();
        c.sck_phase   = rbit();
        c.int_enable  = rbit();
        // mostly fast serial clocks so transfers stay short
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c.rate_select = 3'd4;
            4, 5, 6:    c.rate_select = 3'd0;
            7, 8:       c.rate_select = 3'd5;
            default:    c.rate_select = 3'd1;
        endcase
        load_config(c);
        start = sent_count;
        while (sent_count - start < n) begin
            if ($urandom_range(0, 9) == 0) begin
                for (k = $urandom_range(1, 5); k > 0; k--) send(rand_item());
            end else if (shadow_cfg.master_mode) begin
                run_master_transfer();
            end else begin
                run_slave_transfer();
            end
        end
    endtask

    task automatic test_disabled_access();
        send(mk(spi_msc_pkg::FUNC_STATUS, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        send(mk(spi_msc_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        send(mk(spi_msc_pkg::FUNC_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1));
        send(mk(spi_msc_pkg::FUNC_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_master_corners();
        wait_drained();
        write_reg(spi_msc_pkg::REG_ENABLE, 3'd1);
        write_reg(spi_msc_pkg::REG_MASTER, 3'd1);
        write_reg(spi_msc_pkg::REG_RATE, 3'd3);
        write_reg(spi_msc_pkg::REG_INT_EN, 3'd1);
        send(mk(spi_msc_pkg::FUNC_WRITE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1));
        // second write lands while busy, select low must not matter
        send(mk(spi_msc_pkg::FUNC_WRITE, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
        send(mk(spi_msc_pkg::FUNC_STATUS, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
        wait_drained();
        // shorter period with the prescaler already past it
        write_reg(spi_msc_pkg::REG_RATE, 3'd4);
        send(mk(spi_msc_pkg::FUNC_NONE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1));
        send(mk(spi_msc_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
        wait_drained();
        write_reg(spi_msc_pkg::REG_MASTER, 3'd0);
        send(mk(spi_msc_pkg::FUNC_STATUS, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_slave_corners();
        send(mk(spi_msc_pkg::FUNC_NONE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
        send(mk(spi_msc_pkg::FUNC_NONE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        send(mk(spi_msc_pkg::FUNC_NONE, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
        send(mk(spi_msc_pkg::FUNC_NONE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
        send(mk(spi_msc_pkg::FUNC_WRITE, 8'h81, 1'b0, 1'b0, 1'b1, 1'b1));
        send(mk(spi_msc_pkg::FUNC_NONE, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct, input int n);
        int start;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = sent_count;
        while (sent_count - start < n) run_block($urandom_range(40, 120));
    endtask

    task automatic test_config_extremes();
        int k;
        wait_drained();
        load_config('0);
        for (k = 0; k < 4; k++) send(rand_item());
        wait_drained();
        load_config('1);
        run_master_transfer();
        wait_drained();
        write_reg(spi_msc_pkg::REG_MASTER, 3'd0);
        run_slave_transfer();
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        spi_msc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result transaction: %p", m_data);
            end else begin
                want = pending_outputs.pop_front();
                if (m_data !== want) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"result %0d mismatch: exp rd=%h done=%b irq=%b sck=%b ",
                                  "mosi=%b miso=%b busy=%b, got rd=%h done=%b irq=%b sck=%b ",
                                  "mosi=%b miso=%b busy=%b"}, result_count,
                                 want.read_data, want.done_flag, want.irq, want.sck_out,
                                 want.mosi_out, want.miso_out, want.busy_res,
                                 m_data.read_data, m_data.done_flag, m_data.irq,
                                 m_data.sck_out, m_data.mosi_out, m_data.miso_out,
                                 m_data.busy_res);
                end
            end
            result_count++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        reset_shadow();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_disabled_access();
        test_master_corners();
        test_slave_corners();
        test_random_traffic(30, 51, 300);
        test_random_traffic(51, 30, 300);
        test_random_traffic(0, 0, 300);
        test_config_extremes();
        wait_drained();
        repeat (8) @(posedge aclk);
        error_count += pending_outputs.size();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
